// ===== rtl/core/whp_pkg.sv =====
// Package for the WAV header parser: tags, parse phase codes, status codes,
// register indexes and reset values. No dependencies.
package whp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned HALF_W   = 16;
    localparam int unsigned STATUS_W = 4;
    localparam int unsigned PHASE_W  = 4;
    localparam int unsigned POS_W    = 2;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [WORD_W-1:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [WORD_W-1:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [WORD_W-1:0] TAG_DATA = 32'h6174_6164;
    localparam logic [WORD_W-1:0] TAG_FACT = 32'h7463_6166;
    localparam logic [WORD_W-1:0] FMT_MIN_SIZE = 32'd16;
    localparam logic [WORD_W-1:0] FMT_PCM      = 32'd1;

    localparam logic [PHASE_W-1:0] PH_TYPE     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_SIZE     = 4'd1;
    localparam logic [PHASE_W-1:0] PH_FORM     = 4'd2;
    localparam logic [PHASE_W-1:0] PH_FMT      = 4'd3;
    localparam logic [PHASE_W-1:0] PH_HSIZE    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_FORMAT   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_CHANS    = 4'd6;
    localparam logic [PHASE_W-1:0] PH_FREQ     = 4'd7;
    localparam logic [PHASE_W-1:0] PH_BYSEC    = 4'd8;
    localparam logic [PHASE_W-1:0] PH_BYSAM    = 4'd9;
    localparam logic [PHASE_W-1:0] PH_BISAM    = 4'd10;
    localparam logic [PHASE_W-1:0] PH_SKIPHDR  = 4'd11;
    localparam logic [PHASE_W-1:0] PH_CTAG     = 4'd12;
    localparam logic [PHASE_W-1:0] PH_CLEN     = 4'd13;
    localparam logic [PHASE_W-1:0] PH_SKIPFACT = 4'd14;

    localparam logic [STATUS_W-1:0] ST_OK       = 4'd0;
    localparam logic [STATUS_W-1:0] ST_TRUNC    = 4'd1;
    localparam logic [STATUS_W-1:0] ST_NORIFF   = 4'd2;
    localparam logic [STATUS_W-1:0] ST_NOWAVE   = 4'd3;
    localparam logic [STATUS_W-1:0] ST_NOFMT    = 4'd4;
    localparam logic [STATUS_W-1:0] ST_FMTSMALL = 4'd5;
    localparam logic [STATUS_W-1:0] ST_NOTPCM   = 4'd6;
    localparam logic [STATUS_W-1:0] ST_CHANS    = 4'd7;
    localparam logic [STATUS_W-1:0] ST_RATE     = 4'd8;
    localparam logic [STATUS_W-1:0] ST_ALIGN    = 4'd9;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 4'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN    = 2'd2;

    localparam logic [WORD_W-1:0] RATE_RESET     = 32'd8000;
    localparam logic [HALF_W-1:0] CHANNELS_RESET = 16'd1;
    localparam logic [HALF_W-1:0] ALIGN_RESET    = 16'd2;

    // Byte position at which a field completes; four-byte fields wrap to zero.
    function automatic logic [POS_W-1:0] whp_field_end(input logic [PHASE_W-1:0] phase);
        logic [POS_W-1:0] res;
        begin
            if (phase == PH_FORMAT || phase == PH_CHANS ||
                phase == PH_BYSAM || phase == PH_BISAM) begin
                res = 2'd2;
            end else begin
                res = 2'd0;
            end
            return res;
        end
    endfunction

endpackage

// ===== rtl/core/whp_if.sv =====
// Stream channels of the WAV header parser: byte requests in, results out.
// Depends on whp_pkg.
interface whp_in_if;
    import whp_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              start_of_file;
    logic              end_of_file;

    modport source (output valid, data_byte, start_of_file, end_of_file, input ready);
    modport sink   (input valid, data_byte, start_of_file, end_of_file, output ready);
endinterface

interface whp_res_if;
    import whp_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   data_length;

    modport source (output valid, status, data_length, input ready);
    modport sink   (input valid, status, data_length, output ready);
endinterface

// ===== rtl/core/wav_header_parser.sv =====
// WAV header parser top level: input register, byte parser, result register.
// Depends on whp_pkg and the channel interfaces in whp_if.sv.
//
// The parser takes one byte of a WAV stream per cycle while the result
// register is free or being taken. A byte is registered on acceptance, runs
// through the parse step once the result register can take a result, and any
// result it causes is registered onto the result channel. The whole
// header state (phase, field assembly, skip count) updates in that single
// step. Input ready drops only while a byte is held and the result register
// is full and not being taken. At most one result is given per file; a
// request with start_of_file set begins a new file.
module wav_header_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    whp_in_if.sink                      i_in,
    whp_res_if.source                   o_res,
    input  logic                        i_cfg_we,
    input  logic [whp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [whp_pkg::WORD_W-1:0]  i_cfg_data
);
    import whp_pkg::*;

    logic [WORD_W-1:0]   r_exp_rate;
    logic [HALF_W-1:0]   r_exp_chans;
    logic [HALF_W-1:0]   r_exp_align;

    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_byte;
    logic                r_sof;
    logic                r_eof;

    logic [PHASE_W-1:0]  r_phase;
    logic [POS_W-1:0]    r_pos;
    logic [WORD_W-1:0]   r_word;
    logic [WORD_W-1:0]   r_tag;
    logic [WORD_W-1:0]   r_skip;
    logic                r_fin;

    logic [PHASE_W-1:0]  n_phase;
    logic [POS_W-1:0]    n_pos;
    logic [WORD_W-1:0]   n_word;
    logic [WORD_W-1:0]   n_tag;
    logic [WORD_W-1:0]   n_skip;
    logic                n_fin;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [WORD_W-1:0]   r_len;

    logic                w_go;
    logic                w_emit;
    logic [STATUS_W-1:0] w_status;
    logic [WORD_W-1:0]   w_len;

    assign w_go       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || w_go;

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_status;
    assign o_res.data_length = r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_rate  <= RATE_RESET;
            r_exp_chans <= CHANNELS_RESET;
            r_exp_align <= ALIGN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RATE:     r_exp_rate  <= i_cfg_data;
                CFG_CHANNELS: r_exp_chans <= i_cfg_data[HALF_W-1:0];
                CFG_ALIGN:    r_exp_align <= i_cfg_data[HALF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.data_byte;
            r_sof  <= i_in.start_of_file;
            r_eof  <= i_in.end_of_file;
        end
    end

    always_comb begin
        logic [WORD_W-1:0]   asm_word;
        logic [POS_W-1:0]    pos_inc;
        logic                done;
        logic [STATUS_W-1:0] code;

        n_phase  = r_phase;
        n_pos    = r_pos;
        n_word   = r_word;
        n_tag    = r_tag;
        n_skip   = r_skip;
        n_fin    = r_fin;
        w_emit   = 1'b0;
        w_status = ST_OK;
        w_len    = '0;
        asm_word = '0;
        pos_inc  = '0;
        done     = 1'b0;
        code     = ST_OK;

        if (w_go) begin
            if (r_sof) begin
                n_phase = PH_TYPE;
                n_pos   = '0;
                n_word  = '0;
                n_tag   = '0;
                n_skip  = '0;
                n_fin   = 1'b0;
            end
            if (!n_fin) begin
                if (n_phase == PH_SKIPHDR || n_phase == PH_SKIPFACT) begin
                    n_skip = n_skip - 32'd1;
                    if (n_skip == '0) begin
                        n_phase = PH_CTAG;
                    end
                end else begin
                    unique case (n_pos)
                        2'd0: asm_word = n_word | {24'd0, r_byte};
                        2'd1: asm_word = n_word | {16'd0, r_byte, 8'd0};
                        2'd2: asm_word = n_word | {8'd0, r_byte, 16'd0};
                        2'd3: asm_word = n_word | {r_byte, 24'd0};
                        default: asm_word = n_word;
                    endcase
                    pos_inc = n_pos + 2'd1;
                    if (pos_inc != whp_field_end(n_phase)) begin
                        n_word = asm_word;
                        n_pos  = pos_inc;
                    end else begin
                        n_word = '0;
                        n_pos  = '0;
                        unique case (n_phase)
                            PH_TYPE: begin
                                n_tag   = asm_word;
                                n_phase = PH_SIZE;
                            end
                            PH_SIZE: n_phase = PH_FORM;
                            PH_FORM: begin
                                if (n_tag != TAG_RIFF) begin
                                    done = 1'b1;
                                    code = ST_NORIFF;
                                end else if (asm_word != TAG_WAVE) begin
                                    done = 1'b1;
                                    code = ST_NOWAVE;
                                end else begin
                                    n_phase = PH_FMT;
                                end
                            end
                            PH_FMT: begin
                                if (asm_word != TAG_FMT) begin
                                    done = 1'b1;
                                    code = ST_NOFMT;
                                end else begin
                                    n_phase = PH_HSIZE;
                                end
                            end
                            PH_HSIZE: begin
                                if (asm_word < FMT_MIN_SIZE) begin
                                    done = 1'b1;
                                    code = ST_FMTSMALL;
                                end else begin
                                    n_skip  = asm_word - FMT_MIN_SIZE;
                                    n_phase = PH_FORMAT;
                                end
                            end
                            PH_FORMAT: begin
                                if (asm_word != FMT_PCM) begin
                                    done = 1'b1;
                                    code = ST_NOTPCM;
                                end else begin
                                    n_phase = PH_CHANS;
                                end
                            end
                            PH_CHANS: begin
                                if (asm_word != {16'd0, r_exp_chans}) begin
                                    done = 1'b1;
                                    code = ST_CHANS;
                                end else begin
                                    n_phase = PH_FREQ;
                                end
                            end
                            PH_FREQ: begin
                                if (asm_word != r_exp_rate) begin
                                    done = 1'b1;
                                    code = ST_RATE;
                                end else begin
                                    n_phase = PH_BYSEC;
                                end
                            end
                            PH_BYSEC: n_phase = PH_BYSAM;
                            PH_BYSAM: begin
                                if (asm_word != {16'd0, r_exp_align}) begin
                                    done = 1'b1;
                                    code = ST_ALIGN;
                                end else begin
                                    n_phase = PH_BISAM;
                                end
                            end
                            PH_BISAM: begin
                                n_phase = (n_skip == '0) ? PH_CTAG : PH_SKIPHDR;
                            end
                            PH_CTAG: begin
                                n_tag   = asm_word;
                                n_phase = PH_CLEN;
                            end
                            PH_CLEN: begin
                                if (n_tag == TAG_DATA) begin
                                    done = 1'b1;
                                    code = ST_OK;
                                end else if (n_tag != TAG_FACT) begin
                                    done = 1'b1;
                                    code = ST_UNKNOWN;
                                end else begin
                                    n_skip  = asm_word;
                                    n_phase = (asm_word == '0) ? PH_CTAG : PH_SKIPFACT;
                                end
                            end
                            default: begin
                                n_phase = PH_TYPE;
                                n_tag   = '0;
                                n_skip  = '0;
                            end
                        endcase
                    end
                end
                if (!done && r_eof) begin
                    done = 1'b1;
                    code = ST_TRUNC;
                end
                if (done) begin
                    n_fin    = 1'b1;
                    w_emit   = 1'b1;
                    w_status = code;
                    w_len    = (code == ST_OK) ? asm_word : '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE;
            r_pos   <= '0;
            r_word  <= '0;
            r_tag   <= '0;
            r_skip  <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_word  <= n_word;
            r_tag   <= n_tag;
            r_skip  <= n_skip;
            r_fin   <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_status <= w_status;
            r_len    <= w_len;
        end
    end

    a_len_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status != ST_OK) |-> (r_len == '0))
        else $error("data length set on an error result");

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIPHDR || r_phase == PH_SKIPFACT) |-> (r_skip != '0))
        else $error("skip phase with empty count");

    a_skip_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIPHDR || r_phase == PH_SKIPFACT) |-> (r_pos == '0))
        else $error("skip phase entered mid-field");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go && r_fin && !r_sof |-> !w_emit)
        else $error("second result within one file");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_status <= ST_UNKNOWN))
        else $error("status code out of range");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for wav_header_parser: builds WAV headers with random faults,
// predicts each status and data length, and checks them against the result channel.
// Depends on whp_pkg, whp_if.sv and the wav_header_parser RTL.
`timescale 1ns / 1ps

module testbench;
    import whp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 200;
    localparam int TOTAL_BYTES  = 1400;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   data_length;
    } t_header_verdict;

    typedef enum int {
        FLT_NONE, FLT_RIFF, FLT_WAVE, FLT_FMT, FLT_SMALL, FLT_PCM,
        FLT_CHANS, FLT_RATE, FLT_ALIGN, FLT_CHUNK, FLT_HUGE, FLT_NOISE
    } t_header_fault;

    class t_header_scoreboard;
        logic [WORD_W-1:0]  exp_rate;
        logic [HALF_W-1:0]  exp_channels;
        logic [HALF_W-1:0]  exp_align;
        logic [PHASE_W-1:0] phase;
        logic [POS_W-1:0]   pos;
        logic [WORD_W-1:0]  word;
        logic [WORD_W-1:0]  tag;
        logic [WORD_W-1:0]  skip;
        logic               done;
        t_header_verdict    awaited_verdicts[$];
        int                 mismatches;

        function new();
            exp_rate     = RATE_RESET;
            exp_channels = CHANNELS_RESET;
            exp_align    = ALIGN_RESET;
            mismatches   = 0;
            restart();
        endfunction

        function void restart();
            phase = PH_TYPE;
            pos   = '0;
            word  = '0;
            tag   = '0;
            skip  = '0;
            done  = 1'b0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
            case (idx)
                CFG_RATE:     exp_rate = value;
                CFG_CHANNELS: exp_channels = value[HALF_W-1:0];
                CFG_ALIGN:    exp_align = value[HALF_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited_verdicts.size();
        endfunction

        function void note_request(logic [BYTE_W-1:0] b, logic sof, logic eof);
            t_header_verdict     v;
            logic                hit;
            logic [STATUS_W-1:0] st;
            logic [WORD_W-1:0]   w;
            logic [WORD_W-1:0]   len;
            logic [POS_W-1:0]    field_end;
            hit = 1'b0;
            st  = ST_OK;
            len = '0;
            if (sof)
                restart();
            if (done)
                return;
            if (phase == PH_SKIPHDR || phase == PH_SKIPFACT) begin
                skip = skip - 1;
                if (skip == 0)
                    phase = PH_CTAG;
            end else begin
                word = word | ({24'd0, b} << (8 * pos));
                pos = pos + 1'b1;
                field_end = (phase == PH_FORMAT || phase == PH_CHANS ||
                             phase == PH_BYSAM || phase == PH_BISAM) ? 2'd2 : 2'd0;
                if (pos == field_end) begin
                    w    = word;
                    pos  = '0;
                    word = '0;
                    case (phase)
                        PH_TYPE: begin
                            tag   = w;
                            phase = PH_SIZE;
                        end
                        PH_SIZE: phase = PH_FORM;
                        PH_FORM: begin
                            if (tag != TAG_RIFF) begin
                                hit = 1'b1; st = ST_NORIFF;
                            end else if (w != TAG_WAVE) begin
                                hit = 1'b1; st = ST_NOWAVE;
                            end else begin
                                phase = PH_FMT;
                            end
                        end
                        PH_FMT: begin
                            if (w != TAG_FMT) begin
                                hit = 1'b1; st = ST_NOFMT;
                            end else begin
                                phase = PH_HSIZE;
                            end
                        end
                        PH_HSIZE: begin
                            if (w < FMT_MIN_SIZE) begin
                                hit = 1'b1; st = ST_FMTSMALL;
                            end else begin
                                skip  = w - FMT_MIN_SIZE;
                                phase = PH_FORMAT;
                            end
                        end
                        PH_FORMAT: begin
                            if (w != FMT_PCM) begin
                                hit = 1'b1; st = ST_NOTPCM;
                            end else begin
                                phase = PH_CHANS;
                            end
                        end
                        PH_CHANS: begin
                            if (w != {16'd0, exp_channels}) begin
                                hit = 1'b1; st = ST_CHANS;
                            end else begin
                                phase = PH_FREQ;
                            end
                        end
                        PH_FREQ: begin
                            if (w != exp_rate) begin
                                hit = 1'b1; st = ST_RATE;
                            end else begin
                                phase = PH_BYSEC;
                            end
                        end
                        PH_BYSEC: phase = PH_BYSAM;
                        PH_BYSAM: begin
                            if (w != {16'd0, exp_align}) begin
                                hit = 1'b1; st = ST_ALIGN;
                            end else begin
                                phase = PH_BISAM;
                            end
                        end
                        PH_BISAM: phase = (skip == 0) ? PH_CTAG : PH_SKIPHDR;
                        PH_CTAG: begin
                            tag   = w;
                            phase = PH_CLEN;
                        end
                        PH_CLEN: begin
                            if (tag == TAG_DATA) begin
                                hit = 1'b1; st = ST_OK; len = w;
                            end else if (tag != TAG_FACT) begin
                                hit = 1'b1; st = ST_UNKNOWN;
                            end else begin
                                skip  = w;
                                phase = (w == 0) ? PH_CTAG : PH_SKIPFACT;
                            end
                        end
                        default: restart();
                    endcase
                end
            end
            if (!hit && eof) begin
                hit = 1'b1;
                st  = ST_TRUNC;
            end
            if (hit) begin
                done = 1'b1;
                v.status      = st;
                v.data_length = (st == ST_OK) ? len : '0;
                awaited_verdicts.push_back(v);
            end
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [WORD_W-1:0] length);
            t_header_verdict v;
            if (awaited_verdicts.size() == 0) begin
                $error("unexpected result: status %0d, data_length 0x%08h", status, length);
                mismatches++;
                return;
            end
            v = awaited_verdicts.pop_front();
            if (status !== v.status) begin
                $error("status: expected %0d, actual %0d", v.status, status);
                mismatches++;
            end
            if (length !== v.data_length) begin
                $error("data_length: expected 0x%08h, actual 0x%08h", v.data_length, length);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [WORD_W-1:0]    i_cfg_data;

    whp_in_if  req_if ();
    whp_res_if res_if ();

    wav_header_parser i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_header_scoreboard sb = new();
    logic [BYTE_W-1:0] file_bytes[$];
    bit                no_idle;
    int                bytes_sent;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1)
            sb.check_result(res_if.status, res_if.data_length);
    end

    initial begin
        int stall;
        res_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic sof, input logic eof);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.data_byte     <= b;
        req_if.start_of_file <= sof;
        req_if.end_of_file   <= eof;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        sb.note_request(b, sof, eof);
        bytes_sent++;
    endtask

    // Hold off until every result is in and the pipeline is empty, then write.
    task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [WORD_W-1:0] value);
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.write_register(idx, value);
    endtask

    task automatic put_word(input logic [WORD_W-1:0] value, input int nbytes);
        for (int k = 0; k < nbytes; k++)
            file_bytes.push_back(value[8*k +: 8]);
    endtask

    function automatic logic [WORD_W-1:0] spoil(input logic [WORD_W-1:0] value, input int nbits);
        logic [WORD_W-1:0] mask;
        mask = (nbits == 32) ? 32'hFFFF_FFFF : ((32'd1 << nbits) - 1);
        return value ^ (($urandom() & mask) | (32'd1 << $urandom_range(0, nbits - 1)));
    endfunction

    task automatic build_file(input t_header_fault fault);
        logic [WORD_W-1:0] hsize;
        logic [WORD_W-1:0] len;
        logic [WORD_W-1:0] odd_tag;
        int                extra;
        int                nfact;
        bit                huge_hdr;
        file_bytes.delete();
        if (fault == FLT_NOISE) begin
            repeat ($urandom_range(1, 40))
                file_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
            return;
        end
        huge_hdr = (fault == FLT_HUGE) && $urandom_range(0, 1);
        put_word(fault == FLT_RIFF ? spoil(TAG_RIFF, 32) : TAG_RIFF, 4);
        put_word($urandom(), 4);
        put_word(fault == FLT_WAVE ? spoil(TAG_WAVE, 32) : TAG_WAVE, 4);
        put_word(fault == FLT_FMT ? spoil(TAG_FMT, 32) : TAG_FMT, 4);
        extra = $urandom_range(0, 6);
        hsize = FMT_MIN_SIZE + extra;
        if (fault == FLT_SMALL)
            hsize = $urandom_range(0, 15);
        if (huge_hdr)
            hsize = $urandom() | 32'h8000_0000;
        put_word(hsize, 4);
        put_word(fault == FLT_PCM ? spoil(FMT_PCM, 16) : FMT_PCM, 2);
        put_word(fault == FLT_CHANS ? spoil(sb.exp_channels, 16) : sb.exp_channels, 2);
        put_word(fault == FLT_RATE ? spoil(sb.exp_rate, 32) : sb.exp_rate, 4);
        put_word($urandom(), 4);
        put_word(fault == FLT_ALIGN ? spoil(sb.exp_align, 16) : sb.exp_align, 2);
        put_word($urandom(), 2);
        if (huge_hdr)
            extra = $urandom_range(0, 20);
        repeat (extra) file_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
        nfact = $urandom_range(0, 2);
        for (int k = 0; k < nfact; k++) begin
            len = $urandom_range(0, 5);
            if (fault == FLT_HUGE && !huge_hdr)
                len = $urandom() | 32'h8000_0000;
            put_word(TAG_FACT, 4);
            put_word(len, 4);
            repeat (len > 20 ? 20 : len)
                file_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        if (fault == FLT_CHUNK) begin
            do odd_tag = spoil(TAG_DATA, 32); while (odd_tag == TAG_FACT);
            put_word(odd_tag, 4);
            put_word($urandom(), 4);
        end
        put_word(TAG_DATA, 4);
        case ($urandom_range(0, 3))
            0: len = '0;
            1: len = 32'hFFFF_FFFF;
            default: len = $urandom();
        endcase
        put_word(len, 4);
        repeat ($urandom_range(0, 3)) file_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic send_file(input t_header_fault fault);
        int  n;
        bit  mark_start;
        bit  mark_end;
        bit  noisy;
        build_file(fault);
        noisy = (fault == FLT_NOISE);
        if ($urandom_range(0, 5) == 0)
            file_bytes = file_bytes[0 : $urandom_range(0, file_bytes.size() - 1)];
        n          = file_bytes.size();
        mark_start = noisy ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 9) != 0);
        mark_end   = $urandom_range(0, 9) != 0;
        no_idle    = $urandom_range(0, 3) == 0;
        for (int k = 0; k < n; k++) begin
            if (noisy)
                send_byte(file_bytes[k], k == 0 ? mark_start : ($urandom_range(0, 15) == 0),
                          $urandom_range(0, 7) == 0);
            else
                send_byte(file_bytes[k], k == 0 && mark_start, k == n - 1 && mark_end);
        end
    endtask

    initial begin
        int            setting;
        t_header_fault fault;
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= CFG_RATE;
        i_cfg_data           <= '0;
        req_if.valid         <= 1'b0;
        req_if.data_byte     <= '0;
        req_if.start_of_file <= 1'b0;
        req_if.end_of_file   <= 1'b0;
        no_idle    = 1'b0;
        bytes_sent = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-byte file, an all-ones header, a stray byte after the result,
        // then a restart that runs out of bytes
        send_byte(8'h00, 1'b1, 1'b1);
        for (int k = 0; k < 12; k++)
            send_byte(8'hFF, k == 0, k == 11);
        send_byte(8'hAA, 1'b0, 1'b0);
        for (int k = 0; k < 8; k++)
            send_byte(8'h00, k == 0, k == 7);

        setting = 0;
        while (bytes_sent < TOTAL_BYTES) begin
            if (bytes_sent >= (setting + 1) * PHASE_BYTES) begin
                setting++;
                case (setting)
                    1: begin
                        program_register(CFG_RATE, 32'd0);
                        program_register(CFG_CHANNELS, 32'd0);
                        program_register(CFG_ALIGN, 32'd0);
                    end
                    2: begin
                        program_register(CFG_RATE, 32'hFFFF_FFFF);
                        program_register(CFG_CHANNELS, 32'h0000_FFFF);
                        program_register(CFG_ALIGN, 32'h0000_FFFF);
                    end
                    3: begin
                        program_register(CFG_RATE, 32'd44100);
                        program_register(CFG_CHANNELS, 32'd2);
                        program_register(CFG_ALIGN, 32'd4);
                        program_register(CFG_SPARE, $urandom());
                    end
                    default: begin
                        program_register(CFG_RATE, $urandom());
                        program_register(CFG_CHANNELS, $urandom());
                        program_register(CFG_ALIGN, $urandom());
                    end
                endcase
            end
            if ($urandom_range(0, 1))
                fault = FLT_NONE;
            else
                fault = t_header_fault'($urandom_range(FLT_RIFF, FLT_NOISE));
            send_file(fault);
        end

        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/whp_pkg.sv
rtl/core/whp_if.sv
rtl/core/wav_header_parser.sv
verif/testbench.sv
